### design/qyr_pkg.sv
package qyr_pkg;

    // Input component format: signed Q2.14
    localparam int COMP_W       = 16;
    // Floored product of two components: (a*b) >>> 2
    localparam int PROD_W       = 2 * COMP_W - 2;
    // Sums of products, Q26 with headroom for the doubling
    localparam int SUM_W        = 2 * COMP_W;
    localparam int SUM_FRAC     = 2 * COMP_W - 6;
    // The asin argument is brought from Q26 to Q30 by a left shift
    localparam int ARG_SHIFT    = 30 - SUM_FRAC;

    // Square root of (1.0 - s^2) in Q60, one root bit per stage
    localparam int SQ_W         = 61;
    localparam int ROOT_W       = 31;
    localparam int REM_W        = ROOT_W + 3;
    localparam int VAL_W        = 2 * ROOT_W;
    localparam int SQRT_STAGES  = ROOT_W;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int VEC_W        = 33;
    localparam int ANG_W        = 35;
    localparam int ANG_FRAC     = 30;
    localparam int OUT_FRAC     = 13;
    localparam int RND_W        = ANG_W - (ANG_FRAC - OUT_FRAC);
    // prep (negate, normalize count, shift), iterations, rounding
    localparam int CORDIC_LAT   = CORDIC_STEPS + 4;

    // Output formats
    localparam int YAW_W        = 16;
    localparam int PITCH_W      = 15;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t PI_Q30 = 35'sd3373259426;

    localparam ang_t ATAN_Q30 [ATAN_LEN] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128
    };

endpackage

### design/qyr_cordic.sv
module qyr_cordic
    import qyr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  vec_t                    in_y,
    input  vec_t                    in_x,
    output logic                    out_valid,
    output logic signed [RND_W-1:0] out_angle
);

    localparam int NST = CORDIC_STEPS;

    // left shift that moves the top set bit of m to bit 29
    function automatic logic [4:0] norm_shift(input logic [29:0] m);
        logic [4:0] sh;
        sh = 5'd0;
        for (int b = 0; b < 30; b++) begin
            if (m[b]) begin
                sh = 5'(29 - b);
            end
        end
        return sh;
    endfunction

    // stage 0: fold the left half plane onto the right one
    logic p0_vld_reg, p0_zero_reg;
    vec_t p0_x_reg, p0_y_reg;
    ang_t p0_z_reg;

    // stage 1: normalizing shift amount
    logic p1_vld_reg, p1_zero_reg, p1_right_reg;
    logic [4:0] p1_lsh_reg;
    vec_t p1_x_reg, p1_y_reg;
    ang_t p1_z_reg;

    // iteration stages; index 0 holds the normalized vector
    logic it_vld_reg  [NST+1];
    logic it_zero_reg [NST+1];
    ang_t it_z_reg    [NST+1];
    vec_t it_x_reg    [NST];
    vec_t it_y_reg    [NST];
    vec_t it_x_next   [NST];
    vec_t it_y_next   [NST];
    ang_t it_z_next   [NST];

    logic out_valid_reg;
    logic signed [RND_W-1:0] out_angle_reg;

    vec_t ax, ay, am;
    vec_t n_x, n_y;
    ang_t rnd;

    always_comb begin
        ax = (p0_x_reg < 0) ? -p0_x_reg : p0_x_reg;
        ay = (p0_y_reg < 0) ? -p0_y_reg : p0_y_reg;
        am = (ax > ay) ? ax : ay;
    end

    always_comb begin
        if (p1_right_reg) begin
            n_x = p1_x_reg >>> 1;
            n_y = p1_y_reg >>> 1;
        end else begin
            n_x = p1_x_reg <<< p1_lsh_reg;
            n_y = p1_y_reg <<< p1_lsh_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < NST; i++) begin
            if (it_y_reg[i] < 0) begin
                it_x_next[i] = it_x_reg[i] - (it_y_reg[i] >>> i);
                it_y_next[i] = it_y_reg[i] + (it_x_reg[i] >>> i);
                it_z_next[i] = it_z_reg[i] - ATAN_Q30[i];
            end else begin
                it_x_next[i] = it_x_reg[i] + (it_y_reg[i] >>> i);
                it_y_next[i] = it_y_reg[i] - (it_x_reg[i] >>> i);
                it_z_next[i] = it_z_reg[i] + ATAN_Q30[i];
            end
        end
    end

    assign rnd = it_z_reg[NST] + (ang_t'(1) <<< (ANG_FRAC - OUT_FRAC - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg    <= 1'b0;
            p1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= NST; i++) begin
                it_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            p0_vld_reg    <= in_valid;
            p1_vld_reg    <= p0_vld_reg;
            it_vld_reg[0] <= p1_vld_reg;
            for (int i = 1; i <= NST; i++) begin
                it_vld_reg[i] <= it_vld_reg[i-1];
            end
            out_valid_reg <= it_vld_reg[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_zero_reg <= (in_x == '0) && (in_y == '0);
            if (in_x < 0) begin
                p0_x_reg <= -in_x;
                p0_y_reg <= -in_y;
                p0_z_reg <= (in_y >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                p0_x_reg <= in_x;
                p0_y_reg <= in_y;
                p0_z_reg <= '0;
            end

            p1_zero_reg  <= p0_zero_reg;
            p1_x_reg     <= p0_x_reg;
            p1_y_reg     <= p0_y_reg;
            p1_z_reg     <= p0_z_reg;
            p1_right_reg <= am[30];
            p1_lsh_reg   <= norm_shift(am[29:0]);

            it_x_reg[0]    <= n_x;
            it_y_reg[0]    <= n_y;
            it_z_reg[0]    <= p1_z_reg;
            it_zero_reg[0] <= p1_zero_reg;
            for (int i = 1; i < NST; i++) begin
                it_x_reg[i] <= it_x_next[i-1];
                it_y_reg[i] <= it_y_next[i-1];
            end
            for (int i = 1; i <= NST; i++) begin
                it_z_reg[i]    <= it_z_next[i-1];
                it_zero_reg[i] <= it_zero_reg[i-1];
            end

            // round to Q13; a zero vector gives zero
            if (it_zero_reg[NST]) begin
                out_angle_reg <= '0;
            end else begin
                out_angle_reg <= rnd[ANG_W-1:ANG_FRAC-OUT_FRAC];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_angle = out_angle_reg;

endmodule

### design/quaternion_to_yaw_pitch_roll.sv
// Quaternion to yaw, pitch and roll.
// Input channel s_*: one quaternion per transaction, components in signed
// Q2.14. Output channel m_*: yaw and roll in signed Q3.13 radians, pitch
// in signed Q2.13 radians, plus a flag set when the asin argument had to
// be saturated to +-1. Throughput: one transaction per cycle while the
// output is not stalled. Products, sums, the square of the asin argument,
// a 31-stage square root (one root bit per stage) and three parallel
// CORDIC vectoring pipelines (16 iteration stages each) all take a new
// item every cycle; the square root sets most of the latency.
// The whole pipeline advances together whenever the output register is
// empty or being read. When the receiver stalls with a result held, the
// pipeline freezes in place and s_ready drops; no transaction is lost or
// repeated, and bubbles in the pipe are not squeezed out.
// Reset (aresetn low, synchronous) clears every valid bit; data registers
// are not reset. Output is valid again only for transactions taken after
// reset.
module quaternion_to_yaw_pitch_roll
    import qyr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COMP_W-1:0]  s_quat_x,
    input  logic signed [COMP_W-1:0]  s_quat_y,
    input  logic signed [COMP_W-1:0]  s_quat_z,
    input  logic signed [COMP_W-1:0]  s_quat_w,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [YAW_W-1:0]   m_yaw_angle,
    output logic signed [PITCH_W-1:0] m_pitch_angle,
    output logic signed [YAW_W-1:0]   m_roll_angle,
    output logic                      m_pitch_clamped
);

    // prods, sums, square, root input, then the root stages
    localparam int PRE_STAGES = 4 + SQRT_STAGES;
    // sums stage to root output
    localparam int SIDE_DLY   = PRE_STAGES - 2;

    localparam logic signed [SUM_W-1:0]   ONE_Q     = SUM_W'(1) <<< SUM_FRAC;
    localparam logic [SQ_W-1:0]           ONE_SQ    = SQ_W'(1) <<< (SQ_W - 1);
    localparam logic signed [RND_W-1:0]   YAW_LIM   = 18'sd25736;
    localparam logic signed [RND_W-1:0]   PITCH_LIM = 18'sd12868;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // values that ride alongside the square root
    typedef struct packed {
        sum_t yaw_n;
        sum_t yaw_d;
        sum_t rol_n;
        sum_t rol_d;
        sum_t s;
        logic clamped;
    } side_t;

    function automatic prod_t prod4(input logic signed [COMP_W-1:0] a,
                                    input logic signed [COMP_W-1:0] b);
        logic signed [2*COMP_W-1:0] p;
        p = a * b;
        return p[2*COMP_W-1:2];
    endfunction

    function automatic sum_t ext(input prod_t p);
        return SUM_W'(p);
    endfunction

    logic en;

    logic vld_reg [PRE_STAGES];

    // stage 1: floored products
    prod_t xx_reg, yy_reg, zz_reg, ww_reg;
    prod_t yz_reg, wx_reg, xy_reg, wz_reg, xz_reg, wy_reg;

    // stage 2: atan2 operands and saturated asin argument in Q30
    side_t side_reg;
    side_t side_next;
    sum_t  arg;

    // stages 3 and 4: s^2, then 1.0 - s^2
    logic [ROOT_W-1:0] s_mag;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   v_reg;

    // square root stages
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES-1];
    logic [VAL_W-1:0]  val_reg  [SQRT_STAGES-1];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];
    logic [REM_W-1:0]  rem_src  [SQRT_STAGES];
    logic [VAL_W-1:0]  val_src  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_src [SQRT_STAGES];
    logic [REM_W-1:0]  rem_sh   [SQRT_STAGES];
    logic [REM_W-1:0]  trial    [SQRT_STAGES];
    logic [REM_W-1:0]  rem_next [SQRT_STAGES];
    logic [ROOT_W-1:0] root_next[SQRT_STAGES];

    side_t side_dly_reg [SIDE_DLY];
    logic  clamp_dly_reg [CORDIC_LAT];
    side_t side_c;

    logic                    yaw_vld, pitch_vld, roll_vld;
    logic signed [RND_W-1:0] yaw_r, pitch_r, roll_r;

    logic                      m_valid_reg;
    logic signed [YAW_W-1:0]   yaw_reg, roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic                      clamped_reg;

    // Advance the whole pipe when the output slot is free or being taken.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Form the atan2 operands and saturate the asin argument to +-1.0.
    always_comb begin
        side_next.yaw_n = (ext(yz_reg) + ext(wx_reg)) <<< 1;
        side_next.yaw_d = ext(ww_reg) + ext(xx_reg) - ext(yy_reg) - ext(zz_reg);
        side_next.rol_n = (ext(xy_reg) + ext(wz_reg)) <<< 1;
        side_next.rol_d = ext(ww_reg) - ext(xx_reg) - ext(yy_reg) + ext(zz_reg);
        arg = (ext(wy_reg) - ext(xz_reg)) <<< 1;
        if (arg > ONE_Q) begin
            side_next.s       = ONE_Q <<< ARG_SHIFT;
            side_next.clamped = 1'b1;
        end else if (arg < -ONE_Q) begin
            side_next.s       = (-ONE_Q) <<< ARG_SHIFT;
            side_next.clamped = 1'b1;
        end else begin
            side_next.s       = arg <<< ARG_SHIFT;
            side_next.clamped = 1'b0;
        end
    end

    assign s_mag = (side_reg.s < 0) ? ROOT_W'(-side_reg.s) : ROOT_W'(side_reg.s);

    // Restoring square root: bring down two bits, try root*4+1, keep or drop.
    always_comb begin
        rem_src[0]  = '0;
        root_src[0] = '0;
        val_src[0]  = {1'b0, v_reg};
        for (int k = 1; k < SQRT_STAGES; k++) begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            val_src[k]  = val_reg[k-1];
        end
        for (int k = 0; k < SQRT_STAGES; k++) begin
            rem_sh[k] = {rem_src[k][REM_W-3:0], val_src[k][VAL_W-1 -: 2]};
            trial[k]  = {1'b0, root_src[k], 2'b01};
            if (rem_sh[k] >= trial[k]) begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_src[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_src[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PRE_STAGES; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < PRE_STAGES; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_valid_reg <= yaw_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= prod4(s_quat_x, s_quat_x);
            yy_reg <= prod4(s_quat_y, s_quat_y);
            zz_reg <= prod4(s_quat_z, s_quat_z);
            ww_reg <= prod4(s_quat_w, s_quat_w);
            yz_reg <= prod4(s_quat_y, s_quat_z);
            wx_reg <= prod4(s_quat_w, s_quat_x);
            xy_reg <= prod4(s_quat_x, s_quat_y);
            wz_reg <= prod4(s_quat_w, s_quat_z);
            xz_reg <= prod4(s_quat_x, s_quat_z);
            wy_reg <= prod4(s_quat_w, s_quat_y);

            side_reg <= side_next;
            sq_reg   <= SQ_W'(s_mag) * SQ_W'(s_mag);
            v_reg    <= ONE_SQ - sq_reg;

            for (int k = 0; k < SQRT_STAGES - 1; k++) begin
                rem_reg[k] <= rem_next[k];
                val_reg[k] <= {val_src[k][VAL_W-3:0], 2'b00};
            end
            for (int k = 0; k < SQRT_STAGES; k++) begin
                root_reg[k] <= root_next[k];
            end

            // Hold the side values level with the root.
            side_dly_reg[0] <= side_reg;
            for (int k = 1; k < SIDE_DLY; k++) begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
            clamp_dly_reg[0] <= side_c.clamped;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                clamp_dly_reg[k] <= clamp_dly_reg[k-1];
            end

            // Saturate each angle to its range.
            if (yaw_r > YAW_LIM) begin
                yaw_reg <= YAW_W'(YAW_LIM);
            end else if (yaw_r < -YAW_LIM) begin
                yaw_reg <= YAW_W'(-YAW_LIM);
            end else begin
                yaw_reg <= YAW_W'(yaw_r);
            end
            if (roll_r > YAW_LIM) begin
                roll_reg <= YAW_W'(YAW_LIM);
            end else if (roll_r < -YAW_LIM) begin
                roll_reg <= YAW_W'(-YAW_LIM);
            end else begin
                roll_reg <= YAW_W'(roll_r);
            end
            if (pitch_r > PITCH_LIM) begin
                pitch_reg <= PITCH_W'(PITCH_LIM);
            end else if (pitch_r < -PITCH_LIM) begin
                pitch_reg <= PITCH_W'(-PITCH_LIM);
            end else begin
                pitch_reg <= PITCH_W'(pitch_r);
            end
            clamped_reg <= clamp_dly_reg[CORDIC_LAT-1];
        end
    end

    assign side_c = side_dly_reg[SIDE_DLY-1];

    qyr_cordic u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[PRE_STAGES-1]),
        .in_y      (VEC_W'(side_c.yaw_n)),
        .in_x      (VEC_W'(side_c.yaw_d)),
        .out_valid (yaw_vld),
        .out_angle (yaw_r)
    );

    // pitch = atan2(s, sqrt(1 - s^2))
    qyr_cordic u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[PRE_STAGES-1]),
        .in_y      (VEC_W'(side_c.s)),
        .in_x      ($signed({{(VEC_W-ROOT_W){1'b0}}, root_reg[SQRT_STAGES-1]})),
        .out_valid (pitch_vld),
        .out_angle (pitch_r)
    );

    qyr_cordic u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[PRE_STAGES-1]),
        .in_y      (VEC_W'(side_c.rol_n)),
        .in_x      (VEC_W'(side_c.rol_d)),
        .out_valid (roll_vld),
        .out_angle (roll_r)
    );

    assign m_valid         = m_valid_reg;
    assign m_yaw_angle     = yaw_reg;
    assign m_pitch_angle   = pitch_reg;
    assign m_roll_angle    = roll_reg;
    assign m_pitch_clamped = clamped_reg;

    // The three angle pipelines must stay in lockstep.
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (yaw_vld == pitch_vld) && (yaw_vld == roll_vld))
        else $error("angle pipelines out of step");

    // Saturation keeps every delivered angle in range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_yaw_angle <= 16'sd25736) && (m_yaw_angle >= -16'sd25736) &&
                    (m_roll_angle <= 16'sd25736) && (m_roll_angle >= -16'sd25736) &&
                    (m_pitch_angle <= 15'sd12868) && (m_pitch_angle >= -15'sd12868))
        else $error("angle out of range");

    // Reset empties the output slot.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
